>>> rtl/core/source_tokenizer_assert.svh
// Assertion macros shared by the source tokenizer checkers.
// Include this file by name; it depends on nothing else.
`ifndef SOURCE_TOKENIZER_ASSERT_SVH
`define SOURCE_TOKENIZER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ST_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("source_tokenizer: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define ST_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("source_tokenizer: next-cycle check failed");

`endif

>>> rtl/core/st_pkg.sv
// Package for the source tokenizer: token codes, pending kinds, character
// constants, the token beat struct and the character classification functions.
// Depends on nothing.
package st_pkg;

    // Default width of the offset and length counters.
    localparam int OFFSET_BITS_DEF = 16;
    // Width of the reported offset and length fields.
    localparam int FIELD_BITS = 16;
    // Depth of the output token queue.
    localparam int TOKQ_DEPTH = 4;
    // Number of buffered identifier characters.
    localparam int KW_DEPTH = 6;

    // Token types.
    localparam logic [4:0] TT_ILLEGAL   = 5'd0;
    localparam logic [4:0] TT_EOF       = 5'd1;
    localparam logic [4:0] TT_IDENT     = 5'd2;
    localparam logic [4:0] TT_INT       = 5'd3;
    localparam logic [4:0] TT_ASSIGN    = 5'd4;
    localparam logic [4:0] TT_PLUS      = 5'd5;
    localparam logic [4:0] TT_MINUS     = 5'd6;
    localparam logic [4:0] TT_BANG      = 5'd7;
    localparam logic [4:0] TT_STAR      = 5'd8;
    localparam logic [4:0] TT_SLASH     = 5'd9;
    localparam logic [4:0] TT_LT        = 5'd10;
    localparam logic [4:0] TT_GT        = 5'd11;
    localparam logic [4:0] TT_EQ        = 5'd12;
    localparam logic [4:0] TT_NOTEQ     = 5'd13;
    localparam logic [4:0] TT_COMMA     = 5'd14;
    localparam logic [4:0] TT_SEMICOLON = 5'd15;
    localparam logic [4:0] TT_LPAREN    = 5'd16;
    localparam logic [4:0] TT_RPAREN    = 5'd17;
    localparam logic [4:0] TT_LBRACE    = 5'd18;
    localparam logic [4:0] TT_RBRACE    = 5'd19;
    localparam logic [4:0] TT_FN        = 5'd20;
    localparam logic [4:0] TT_LET       = 5'd21;
    localparam logic [4:0] TT_TRUE      = 5'd22;
    localparam logic [4:0] TT_FALSE     = 5'd23;
    localparam logic [4:0] TT_IF        = 5'd24;
    localparam logic [4:0] TT_ELSE      = 5'd25;
    localparam logic [4:0] TT_RETURN    = 5'd26;

    // Kind of token under construction.
    localparam logic [2:0] PK_NONE   = 3'd0;
    localparam logic [2:0] PK_IDENT  = 3'd1;
    localparam logic [2:0] PK_INT    = 3'd2;
    localparam logic [2:0] PK_ASSIGN = 3'd3;
    localparam logic [2:0] PK_BANG   = 3'd4;

    // Characters with a role of their own.
    localparam logic [7:0] CH_NUL        = 8'h00;
    localparam logic [7:0] CH_TAB        = 8'h09;
    localparam logic [7:0] CH_LF         = 8'h0A;
    localparam logic [7:0] CH_CR         = 8'h0D;
    localparam logic [7:0] CH_SPACE      = 8'h20;
    localparam logic [7:0] CH_EQUALS     = 8'h3D;
    localparam logic [7:0] CH_BANG       = 8'h21;
    localparam logic [7:0] CH_UNDERSCORE = 8'h5F;

    // Keyword spellings, first character in the top byte.
    localparam logic [15:0] KW_FN     = "fn";
    localparam logic [15:0] KW_IF     = "if";
    localparam logic [23:0] KW_LET    = "let";
    localparam logic [31:0] KW_TRUE   = "true";
    localparam logic [31:0] KW_ELSE   = "else";
    localparam logic [39:0] KW_FALSE  = "false";
    localparam logic [47:0] KW_RETURN = "return";

    // One token beat as it leaves the block.
    typedef struct packed {
        logic [4:0]            token_type;
        logic [FIELD_BITS-1:0] start_offset;
        logic [FIELD_BITS-1:0] token_length;
        logic                  last;
    } t_token;

    // First characters of an identifier; entry 0 is the first character.
    typedef logic [KW_DEPTH-1:0][7:0] t_kw_buf;

    // Write request into the keyword buffer.
    typedef struct packed {
        logic       we;
        logic [2:0] idx;
        logic [7:0] data;
    } t_kw_write;

    // Letters and underscore make up identifiers.
    function automatic logic is_word_char(input logic [7:0] c);
        return c inside {[8'h61:8'h7A], [8'h41:8'h5A], CH_UNDERSCORE};
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c inside {[8'h30:8'h39]};
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return c inside {CH_SPACE, CH_TAB, CH_LF, CH_CR};
    endfunction

    // Token type of a single-character operator or delimiter.
    function automatic logic [4:0] single_type(input logic [7:0] c);
        logic [4:0] t;
        case (c)
            8'h2B:   t = TT_PLUS;
            8'h2D:   t = TT_MINUS;
            8'h2A:   t = TT_STAR;
            8'h2F:   t = TT_SLASH;
            8'h3C:   t = TT_LT;
            8'h3E:   t = TT_GT;
            8'h2C:   t = TT_COMMA;
            8'h3B:   t = TT_SEMICOLON;
            8'h28:   t = TT_LPAREN;
            8'h29:   t = TT_RPAREN;
            8'h7B:   t = TT_LBRACE;
            8'h7D:   t = TT_RBRACE;
            default: t = TT_ILLEGAL;
        endcase
        return t;
    endfunction

    // Keyword lookup from the buffered characters and an identifier length
    // of at most six.
    function automatic logic [4:0] kw_type(input t_kw_buf b, input logic [2:0] len);
        logic [4:0] t;
        t = TT_IDENT;
        case (len)
            3'd2: begin
                if ({b[0], b[1]} == KW_FN) t = TT_FN;
                else if ({b[0], b[1]} == KW_IF) t = TT_IF;
            end
            3'd3: begin
                if ({b[0], b[1], b[2]} == KW_LET) t = TT_LET;
            end
            3'd4: begin
                if ({b[0], b[1], b[2], b[3]} == KW_TRUE) t = TT_TRUE;
                else if ({b[0], b[1], b[2], b[3]} == KW_ELSE) t = TT_ELSE;
            end
            3'd5: begin
                if ({b[0], b[1], b[2], b[3], b[4]} == KW_FALSE) t = TT_FALSE;
            end
            3'd6: begin
                if ({b[0], b[1], b[2], b[3], b[4], b[5]} == KW_RETURN) t = TT_RETURN;
            end
            default: t = TT_IDENT;
        endcase
        return t;
    endfunction

endpackage

>>> rtl/core/source_tokenizer.sv
// Source tokenizer: one character per beat in, one token per beat out.
// A character passes the input register and then the token queue.
// Throughput: 1 character per cycle; the step stalls while the 4-entry token queue
// holds more than 2 tokens, so characters that cause two tokens use output cycles.
// Reset (synchronous, active low) clears the tokenizer state, offset, input
// register and queue; the keyword buffer is not cleared.
module source_tokenizer #(
    parameter int OFFSET_BITS = st_pkg::OFFSET_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_ch,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [4:0]  o_token_type,
    output logic [15:0] o_start_offset,
    output logic [15:0] o_token_length,
    output logic        o_last
);

    localparam int CNT_W = $clog2(st_pkg::TOKQ_DEPTH + 1);

    logic                   r_ch_valid;
    logic [7:0]             r_ch;
    logic [2:0]             r_kind;
    logic [OFFSET_BITS-1:0] r_start;
    logic [OFFSET_BITS-1:0] r_len;
    logic [OFFSET_BITS-1:0] r_off;
    st_pkg::t_kw_buf        r_kw_buf;

    logic [2:0]             n_kind;
    logic [OFFSET_BITS-1:0] n_start;
    logic [OFFSET_BITS-1:0] n_len;
    logic [OFFSET_BITS-1:0] n_off;
    st_pkg::t_kw_write      kw_wr;
    logic [1:0]             tok_cnt;
    st_pkg::t_token         tok0;
    st_pkg::t_token         tok1;
    st_pkg::t_token         q_tok;
    logic [CNT_W-1:0]       q_count;
    logic                   fire;
    logic                   pop;

    // The step runs when a character is held and the queue has room for two.
    assign fire    = r_ch_valid && (q_count <= CNT_W'(st_pkg::TOKQ_DEPTH - 2));
    assign o_ready = !r_ch_valid || fire;
    assign pop     = o_valid && i_ready;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ch_valid <= 1'b0;
        end else if (o_ready) begin
            r_ch_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_ch <= i_ch;
        end
    end

    st_step #(
        .OFFSET_BITS(OFFSET_BITS)
    ) u_step (
        .i_ch      (r_ch),
        .i_kind    (r_kind),
        .i_start   (r_start),
        .i_len     (r_len),
        .i_off     (r_off),
        .i_kw_buf  (r_kw_buf),
        .o_kind    (n_kind),
        .o_start   (n_start),
        .o_len     (n_len),
        .o_off     (n_off),
        .o_kw_wr   (kw_wr),
        .o_tok_cnt (tok_cnt),
        .o_tok0    (tok0),
        .o_tok1    (tok1)
    );

    // Tokenizer state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kind  <= st_pkg::PK_NONE;
            r_start <= '0;
            r_len   <= '0;
            r_off   <= '0;
        end else if (fire) begin
            r_kind  <= n_kind;
            r_start <= n_start;
            r_len   <= n_len;
            r_off   <= n_off;
        end
    end

    // Keyword buffer holds the first characters of the current identifier.
    always_ff @(posedge i_clk) begin
        if (fire && kw_wr.we) begin
            r_kw_buf[kw_wr.idx] <= kw_wr.data;
        end
    end

    st_token_fifo u_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push_cnt (fire ? tok_cnt : 2'd0),
        .i_tok0     (tok0),
        .i_tok1     (tok1),
        .i_pop      (pop),
        .o_count    (q_count),
        .o_tok      (q_tok)
    );

    assign o_valid        = (q_count != '0);
    assign o_token_type   = q_tok.token_type;
    assign o_start_offset = q_tok.start_offset;
    assign o_token_length = q_tok.token_length;
    assign o_last         = q_tok.last;

endmodule

>>> rtl/core/st_step.sv
// Combinational next-state and token logic of the source tokenizer for one
// character. Depends on st_pkg.
module st_step #(
    parameter int OFFSET_BITS = st_pkg::OFFSET_BITS_DEF
) (
    input  logic [7:0]             i_ch,
    input  logic [2:0]             i_kind,
    input  logic [OFFSET_BITS-1:0] i_start,
    input  logic [OFFSET_BITS-1:0] i_len,
    input  logic [OFFSET_BITS-1:0] i_off,
    input  st_pkg::t_kw_buf        i_kw_buf,
    output logic [2:0]             o_kind,
    output logic [OFFSET_BITS-1:0] o_start,
    output logic [OFFSET_BITS-1:0] o_len,
    output logic [OFFSET_BITS-1:0] o_off,
    output st_pkg::t_kw_write      o_kw_wr,
    output logic [1:0]             o_tok_cnt,
    output st_pkg::t_token         o_tok0,
    output st_pkg::t_token         o_tok1
);

    localparam logic [OFFSET_BITS-1:0] OFF_MAX = '1;

    function automatic logic [OFFSET_BITS-1:0] sat_inc(input logic [OFFSET_BITS-1:0] v);
        return (v == OFF_MAX) ? v : v + OFFSET_BITS'(1);
    endfunction

    // Clamp a counter value to the reported field width.
    function automatic logic [st_pkg::FIELD_BITS-1:0] clamp(
        input logic [OFFSET_BITS-1:0] v
    );
        logic [31:0] w;
        w = 32'(v);
        return (w > 32'h0000_FFFF) ? 16'hFFFF : w[st_pkg::FIELD_BITS-1:0];
    endfunction

    st_pkg::t_token flush_tok;
    st_pkg::t_token cur_tok;
    logic           flush_v;
    logic           cur_v;
    logic           consumed;

    // Resolve the pending token, then handle the character from idle.
    always_comb begin
        flush_v   = 1'b0;
        cur_v     = 1'b0;
        consumed  = 1'b0;
        flush_tok = '0;
        cur_tok   = '0;
        o_kind    = i_kind;
        o_start   = i_start;
        o_len     = i_len;
        o_off     = i_off;
        o_kw_wr.we   = 1'b0;
        o_kw_wr.idx  = i_len[2:0];
        o_kw_wr.data = i_ch;

        case (i_kind)
            st_pkg::PK_IDENT: begin
                if (st_pkg::is_word_char(i_ch)) begin
                    o_kw_wr.we = (i_len < OFFSET_BITS'(st_pkg::KW_DEPTH));
                    o_len      = sat_inc(i_len);
                    o_off      = sat_inc(i_off);
                    consumed   = 1'b1;
                end else begin
                    flush_v                = 1'b1;
                    flush_tok.token_type   = (i_len <= OFFSET_BITS'(st_pkg::KW_DEPTH)) ?
                                             st_pkg::kw_type(i_kw_buf, i_len[2:0]) :
                                             st_pkg::TT_IDENT;
                    flush_tok.start_offset = clamp(i_start);
                    flush_tok.token_length = clamp(i_len);
                end
            end
            st_pkg::PK_INT: begin
                if (st_pkg::is_digit(i_ch)) begin
                    o_len    = sat_inc(i_len);
                    o_off    = sat_inc(i_off);
                    consumed = 1'b1;
                end else begin
                    flush_v                = 1'b1;
                    flush_tok.token_type   = st_pkg::TT_INT;
                    flush_tok.start_offset = clamp(i_start);
                    flush_tok.token_length = clamp(i_len);
                end
            end
            st_pkg::PK_ASSIGN, st_pkg::PK_BANG: begin
                flush_v                = 1'b1;
                flush_tok.start_offset = clamp(i_start);
                if (i_ch == st_pkg::CH_EQUALS) begin
                    flush_tok.token_type   = (i_kind == st_pkg::PK_ASSIGN) ?
                                             st_pkg::TT_EQ : st_pkg::TT_NOTEQ;
                    flush_tok.token_length = 16'd2;
                    o_kind                 = st_pkg::PK_NONE;
                    o_off                  = sat_inc(i_off);
                    consumed               = 1'b1;
                end else begin
                    flush_tok.token_type   = (i_kind == st_pkg::PK_ASSIGN) ?
                                             st_pkg::TT_ASSIGN : st_pkg::TT_BANG;
                    flush_tok.token_length = 16'd1;
                end
            end
            default: ;
        endcase

        if (!consumed) begin
            o_kind = st_pkg::PK_NONE;
            if (i_ch == st_pkg::CH_NUL) begin
                // End of text: emit EOF and restart the offset.
                cur_v                = 1'b1;
                cur_tok.token_type   = st_pkg::TT_EOF;
                cur_tok.start_offset = clamp(i_off);
                cur_tok.token_length = '0;
                o_off                = '0;
            end else begin
                o_off = sat_inc(i_off);
                if (st_pkg::is_space(i_ch)) begin
                    o_kind = st_pkg::PK_NONE;
                end else if (i_ch == st_pkg::CH_EQUALS || i_ch == st_pkg::CH_BANG) begin
                    o_kind  = (i_ch == st_pkg::CH_EQUALS) ? st_pkg::PK_ASSIGN : st_pkg::PK_BANG;
                    o_start = i_off;
                    o_len   = OFFSET_BITS'(1);
                end else if (st_pkg::is_word_char(i_ch)) begin
                    o_kind      = st_pkg::PK_IDENT;
                    o_start     = i_off;
                    o_len       = OFFSET_BITS'(1);
                    o_kw_wr.we  = 1'b1;
                    o_kw_wr.idx = 3'd0;
                end else if (st_pkg::is_digit(i_ch)) begin
                    o_kind  = st_pkg::PK_INT;
                    o_start = i_off;
                    o_len   = OFFSET_BITS'(1);
                end else begin
                    cur_v                = 1'b1;
                    cur_tok.token_type   = st_pkg::single_type(i_ch);
                    cur_tok.start_offset = clamp(i_off);
                    cur_tok.token_length = 16'd1;
                end
            end
        end

        // Order the beats: the flushed token goes first, last marks the final one.
        cur_tok.last = 1'b1;
        if (flush_v) begin
            flush_tok.last = !cur_v;
            o_tok0         = flush_tok;
            o_tok1         = cur_tok;
            o_tok_cnt      = cur_v ? 2'd2 : 2'd1;
        end else begin
            o_tok0    = cur_tok;
            o_tok1    = cur_tok;
            o_tok_cnt = {1'b0, cur_v};
        end
    end

endmodule

>>> rtl/core/st_token_fifo.sv
// Small token queue of the source tokenizer: takes up to two beats per cycle
// and hands out one. Depends on st_pkg.
module st_token_fifo (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic [1:0]                             i_push_cnt,
    input  st_pkg::t_token                         i_tok0,
    input  st_pkg::t_token                         i_tok1,
    input  logic                                   i_pop,
    output logic [$clog2(st_pkg::TOKQ_DEPTH+1)-1:0] o_count,
    output st_pkg::t_token                         o_tok
);

    localparam int DEPTH = st_pkg::TOKQ_DEPTH;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    st_pkg::t_token r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_count;
    logic [PTR_W-1:0] wr_next;

    assign wr_next = r_wr + PTR_W'(1);

    // Entry storage: one or two beats land per cycle.
    always_ff @(posedge i_clk) begin
        if (i_push_cnt != 2'd0) begin
            r_mem[r_wr] <= i_tok0;
        end
        if (i_push_cnt == 2'd2) begin
            r_mem[wr_next] <= i_tok1;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= r_wr + PTR_W'(i_push_cnt);
            r_rd    <= r_rd + PTR_W'(i_pop);
            r_count <= r_count + CNT_W'(i_push_cnt) - CNT_W'(i_pop);
        end
    end

    assign o_count = r_count;
    assign o_tok   = r_mem[r_rd];

endmodule

>>> rtl/core/st_checker.sv
// Port-level checks of the source tokenizer, bound to the top level.
// Depends on st_pkg and source_tokenizer_assert.svh.
`include "source_tokenizer_assert.svh"

module st_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_ready,
    input logic        o_valid,
    input logic        i_ready,
    input logic [4:0]  o_token_type,
    input logic [15:0] o_start_offset,
    input logic [15:0] o_token_length,
    input logic        o_last
);

    logic [37:0] beat;
    logic        eof_beat;
    logic        eqop_beat;

    // Whole token beat and the token kinds with a fixed shape.
    assign beat      = {o_token_type, o_start_offset, o_token_length, o_last};
    assign eof_beat  = o_valid && (o_token_type == st_pkg::TT_EOF);
    assign eqop_beat = o_valid &&
                       (o_token_type == st_pkg::TT_EQ || o_token_type == st_pkg::TT_NOTEQ);

    // A stalled token beat stays offered and keeps its payload.
    `ST_ASSERT_NEXT(a_out_stable, i_clk, i_rst_n, o_valid && !i_ready, o_valid && $stable(beat))

    // With no token waiting the block always takes a character.
    `ST_ASSERT_SAME(a_ready_when_empty, i_clk, i_rst_n, !o_valid, o_ready)

    // EOF carries no characters and always closes its character's tokens.
    `ST_ASSERT_SAME(a_eof_shape, i_clk, i_rst_n, eof_beat, o_token_length == 16'd0 && o_last)

    // Two-character operators report length two and end their character's tokens.
    `ST_ASSERT_SAME(a_eqop_shape, i_clk, i_rst_n, eqop_beat, o_token_length == 16'd2 && o_last)

    // A beat that is not the last one for its character is followed by another.
    `ST_ASSERT_NEXT(a_pair_follows, i_clk, i_rst_n, o_valid && i_ready && !o_last, o_valid)

endmodule

bind source_tokenizer st_checker u_st_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_ready        (o_ready),
    .o_valid        (o_valid),
    .i_ready        (i_ready),
    .o_token_type   (o_token_type),
    .o_start_offset (o_start_offset),
    .o_token_length (o_token_length),
    .o_last         (o_last)
);

>>> sim/token_checker.sv
// Token checker for the source tokenizer: watches both beat channels, predicts the
// token stream from the accepted characters and compares every token beat.
// Depends on st_pkg for the token codes, pending kinds and the token struct.
`timescale 1ns / 1ps

module token_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_ch_valid,
    input  logic        i_ch_ready,
    input  logic [7:0]  i_ch,
    input  logic        i_tok_valid,
    input  logic        i_tok_ready,
    input  logic [4:0]  i_token_type,
    input  logic [15:0] i_start_offset,
    input  logic [15:0] i_token_length,
    input  logic        i_last,
    output int          o_fail_count,
    output int          o_tokens_due,
    output int          o_tokens_checked,
    output logic [26:0] o_types_seen
);

    // Shadow lexer state.
    logic [15:0]     next_offset;
    logic [2:0]      word_kind;
    logic [15:0]     word_start;
    logic [15:0]     word_len;
    st_pkg::t_kw_buf word_chars;

    // Tokens predicted but not yet seen on the output, oldest first.
    st_pkg::t_token  expected_tokens[$];
    st_pkg::t_token  step_tokens[2];
    int              step_count;
    st_pkg::t_token  want;
    int              mismatches;
    int              checked;
    logic [26:0]     kinds_seen;

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") ||
               c == st_pkg::CH_UNDERSCORE;
    endfunction

    function automatic logic is_num(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic [15:0] sat_next(input logic [15:0] v);
        return (v == 16'hFFFF) ? v : v + 16'd1;
    endfunction

    function automatic logic [4:0] punct_type(input logic [7:0] c);
        logic [4:0] t;
        case (c)
            "+":     t = st_pkg::TT_PLUS;
            "-":     t = st_pkg::TT_MINUS;
            "*":     t = st_pkg::TT_STAR;
            "/":     t = st_pkg::TT_SLASH;
            "<":     t = st_pkg::TT_LT;
            ">":     t = st_pkg::TT_GT;
            ",":     t = st_pkg::TT_COMMA;
            ";":     t = st_pkg::TT_SEMICOLON;
            "(":     t = st_pkg::TT_LPAREN;
            ")":     t = st_pkg::TT_RPAREN;
            "{":     t = st_pkg::TT_LBRACE;
            "}":     t = st_pkg::TT_RBRACE;
            default: t = st_pkg::TT_ILLEGAL;
        endcase
        return t;
    endfunction

    // Walk the keyword table; spellings are left aligned in 48 bits.
    function automatic logic [4:0] word_type(input st_pkg::t_kw_buf w,
                                             input logic [15:0] len);
        logic [47:0] spell;
        logic [4:0]  code;
        logic [4:0]  result;
        logic        hit;
        int          n;
        int          k;
        int          i;
        result = st_pkg::TT_IDENT;
        for (k = 0; k < 7; k++) begin
            case (k)
                0: begin
                    spell = {st_pkg::KW_FN, 32'd0};    n = 2; code = st_pkg::TT_FN;
                end
                1: begin
                    spell = {st_pkg::KW_LET, 24'd0};   n = 3; code = st_pkg::TT_LET;
                end
                2: begin
                    spell = {st_pkg::KW_TRUE, 16'd0};  n = 4; code = st_pkg::TT_TRUE;
                end
                3: begin
                    spell = {st_pkg::KW_FALSE, 8'd0};  n = 5; code = st_pkg::TT_FALSE;
                end
                4: begin
                    spell = {st_pkg::KW_IF, 32'd0};    n = 2; code = st_pkg::TT_IF;
                end
                5: begin
                    spell = {st_pkg::KW_ELSE, 16'd0};  n = 4; code = st_pkg::TT_ELSE;
                end
                default: begin
                    spell = st_pkg::KW_RETURN;         n = 6; code = st_pkg::TT_RETURN;
                end
            endcase
            if (len == n) begin
                hit = 1'b1;
                for (i = 0; i < n; i++) begin
                    if (w[i] != spell[47 - 8 * i -: 8]) hit = 1'b0;
                end
                if (hit) result = code;
            end
        end
        return result;
    endfunction

    task automatic queue_token(input logic [4:0] tt, input logic [15:0] start,
                               input logic [15:0] len);
        step_tokens[step_count] = {tt, start, len, 1'b0};
        step_count++;
    endtask

    // Advance the shadow lexer by one character and queue the tokens it closes.
    task automatic predict_tokens(input logic [7:0] c);
        logic [15:0]    here;
        logic           done;
        st_pkg::t_token tok;
        int             i;
        step_count = 0;
        here = next_offset;
        done = 1'b0;

        // First settle the token that is still open.
        case (word_kind)
            st_pkg::PK_IDENT: begin
                if (is_alpha(c)) begin
                    if (word_len < st_pkg::KW_DEPTH) word_chars[word_len[2:0]] = c;
                    word_len = sat_next(word_len);
                    next_offset = sat_next(here);
                    done = 1'b1;
                end else begin
                    queue_token(word_type(word_chars, word_len), word_start, word_len);
                end
            end
            st_pkg::PK_INT: begin
                if (is_num(c)) begin
                    word_len = sat_next(word_len);
                    next_offset = sat_next(here);
                    done = 1'b1;
                end else begin
                    queue_token(st_pkg::TT_INT, word_start, word_len);
                end
            end
            st_pkg::PK_ASSIGN, st_pkg::PK_BANG: begin
                if (c == st_pkg::CH_EQUALS) begin
                    queue_token((word_kind == st_pkg::PK_ASSIGN) ?
                                st_pkg::TT_EQ : st_pkg::TT_NOTEQ, word_start, 16'd2);
                    word_kind = st_pkg::PK_NONE;
                    next_offset = sat_next(here);
                    done = 1'b1;
                end else begin
                    queue_token((word_kind == st_pkg::PK_ASSIGN) ?
                                st_pkg::TT_ASSIGN : st_pkg::TT_BANG, word_start, 16'd1);
                end
            end
            default: ;
        endcase

        // Then treat the character as the start of something new.
        if (!done) begin
            word_kind = st_pkg::PK_NONE;
            if (c == st_pkg::CH_NUL) begin
                queue_token(st_pkg::TT_EOF, here, 16'd0);
                next_offset = 16'd0;
            end else begin
                next_offset = sat_next(here);
                if (c == st_pkg::CH_SPACE || c == st_pkg::CH_TAB ||
                    c == st_pkg::CH_LF || c == st_pkg::CH_CR) begin
                    // Whitespace only moves the offset.
                end else if (c == st_pkg::CH_EQUALS || c == st_pkg::CH_BANG) begin
                    word_kind = (c == st_pkg::CH_EQUALS) ? st_pkg::PK_ASSIGN : st_pkg::PK_BANG;
                    word_start = here;
                    word_len = 16'd1;
                end else if (is_alpha(c)) begin
                    word_kind = st_pkg::PK_IDENT;
                    word_start = here;
                    word_len = 16'd1;
                    word_chars[0] = c;
                end else if (is_num(c)) begin
                    word_kind = st_pkg::PK_INT;
                    word_start = here;
                    word_len = 16'd1;
                end else begin
                    queue_token(punct_type(c), here, 16'd1);
                end
            end
        end

        for (i = 0; i < step_count; i++) begin
            tok = step_tokens[i];
            tok.last = (i == step_count - 1);
            expected_tokens.push_back(tok);
        end
    endtask

    task automatic check_field(input string name, input logic [15:0] exp_v,
                               input logic [15:0] got_v);
        if (got_v !== exp_v) begin
            $error("%s: expected %0d, got %0d", name, exp_v, got_v);
            mismatches++;
        end
    endtask

    // Compare token beats first, then fold in the character beat of this edge.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            next_offset = 16'd0;
            word_kind = st_pkg::PK_NONE;
            word_start = 16'd0;
            word_len = 16'd0;
            word_chars = '0;
            expected_tokens.delete();
            mismatches = 0;
            checked = 0;
            kinds_seen = '0;
        end else begin
            if (i_tok_valid && i_tok_ready) begin
                if (expected_tokens.size() == 0) begin
                    $error("token beat with nothing expected: type %0d, offset %0d",
                           i_token_type, i_start_offset);
                    mismatches++;
                end else begin
                    want = expected_tokens.pop_front();
                    checked++;
                    if (want.token_type < 27) kinds_seen[want.token_type] = 1'b1;
                    check_field("token_type", 16'(want.token_type), 16'(i_token_type));
                    check_field("start_offset", want.start_offset, i_start_offset);
                    check_field("token_length", want.token_length, i_token_length);
                    check_field("last", 16'(want.last), 16'(i_last));
                end
            end
            if (i_ch_valid && i_ch_ready) predict_tokens(i_ch);
        end
        o_fail_count <= mismatches;
        o_tokens_due <= expected_tokens.size();
        o_tokens_checked <= checked;
        o_types_seen <= kinds_seen;
    end

endmodule

>>> sim/testbench.sv
// Top of the source tokenizer testbench: clock, reset, character stimulus and
// token back-pressure, with the verdict taken from token_checker.
// Depends on st_pkg, source_tokenizer and token_checker.
`timescale 1ns / 1ps

module testbench;

    localparam int     TEXT_CHARS   = 1540;
    localparam int     LONG_HOLD    = 400;
    localparam int     LONG_WORD    = 20;
    localparam int     END_SLACK    = 20;
    localparam longint LIMIT_NS     = 10_000_000;

    logic        clk;
    logic        rst_n     = 1'b0;
    logic        ch_valid  = 1'b0;
    logic [7:0]  ch_data   = st_pkg::CH_NUL;
    logic        tok_ready = 1'b0;
    logic        ch_ready;
    logic        tok_valid;
    logic [4:0]  tok_type;
    logic [15:0] tok_start;
    logic [15:0] tok_len;
    logic        tok_last;

    int          fail_count;
    int          tokens_due;
    int          tokens_checked;
    logic [26:0] types_seen;

    // Shared between the character and token sides.
    bit          sender_steady   = 1'b0;
    bit          receiver_steady = 1'b0;
    bit          hold_request    = 1'b0;
    int          chars_sent      = 0;

    source_tokenizer dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_valid        (ch_valid),
        .o_ready        (ch_ready),
        .i_ch           (ch_data),
        .o_valid        (tok_valid),
        .i_ready        (tok_ready),
        .o_token_type   (tok_type),
        .o_start_offset (tok_start),
        .o_token_length (tok_len),
        .o_last         (tok_last)
    );

    token_checker u_token_check (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_ch_valid       (ch_valid),
        .i_ch_ready       (ch_ready),
        .i_ch             (ch_data),
        .i_tok_valid      (tok_valid),
        .i_tok_ready      (tok_ready),
        .i_token_type     (tok_type),
        .i_start_offset   (tok_start),
        .i_token_length   (tok_len),
        .i_last           (tok_last),
        .o_fail_count     (fail_count),
        .o_tokens_due     (tokens_due),
        .o_tokens_checked (tokens_checked),
        .o_types_seen     (types_seen)
    );

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [7:0] random_letter();
        int r;
        r = $urandom_range(0, 52);
        if (r < 26) return 8'("a" + r);
        if (r < 52) return 8'("A" + r - 26);
        return st_pkg::CH_UNDERSCORE;
    endfunction

    function automatic string keyword_text(input int k);
        case (k)
            0:       return "fn";
            1:       return "let";
            2:       return "true";
            3:       return "false";
            4:       return "if";
            5:       return "else";
            default: return "return";
        endcase
    endfunction

    // One character beat, then an optional idle gap.
    task automatic send_char(input logic [7:0] c);
        int gap;
        ch_valid <= 1'b1;
        ch_data  <= c;
        @(posedge clk);
        while (!ch_ready) @(posedge clk);
        chars_sent++;
        gap = sender_steady ? 0 : pick_gap();
        if (gap > 0) begin
            ch_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++) send_char(s[i]);
    endtask

    // Stop offering characters until every predicted token has come out.
    task automatic drain_tokens();
        ch_valid <= 1'b0;
        @(posedge clk);
        while (tokens_due != 0) @(posedge clk);
    endtask

    // One lexical word with random content; a few are noise or end the text.
    task automatic send_word();
        string ops;
        string kw;
        int    r;
        int    n;
        int    i;
        ops = "+-*/<>,;(){}";
        r = $urandom_range(0, 99);
        if (r < 18) begin
            send_text(keyword_text($urandom_range(0, 6)));
        end else if (r < 24) begin
            // Near misses: one letter too many or one too few.
            kw = keyword_text($urandom_range(0, 6));
            if ($urandom_range(0, 1)) begin
                send_text(kw);
                send_char(random_letter());
            end else begin
                for (i = 0; i < kw.len() - 1; i++) send_char(kw[i]);
            end
        end else if (r < 40) begin
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 12) : $urandom_range(1, 6);
            for (i = 0; i < n; i++) send_char(random_letter());
        end else if (r < 52) begin
            n = $urandom_range(1, 6);
            for (i = 0; i < n; i++) send_char(8'("0" + $urandom_range(0, 9)));
        end else if (r < 64) begin
            send_char(ops[$urandom_range(0, 11)]);
        end else if (r < 72) begin
            case ($urandom_range(0, 4))
                0:       send_text("=");
                1:       send_text("!");
                2:       send_text("==");
                3:       send_text("!=");
                default: send_text("===");
            endcase
        end else if (r < 90) begin
            case ($urandom_range(0, 3))
                0:       send_char(st_pkg::CH_SPACE);
                1:       send_char(st_pkg::CH_TAB);
                2:       send_char(st_pkg::CH_LF);
                default: send_char(st_pkg::CH_CR);
            endcase
        end else if (r < 97) begin
            send_char(8'($urandom_range(1, 255)));
        end else begin
            send_char(st_pkg::CH_NUL);
        end
    endtask

    // Token side: random stalls, quiet stretches and one long hold on request.
    initial begin
        int stall;
        @(posedge clk);
        forever begin
            if (hold_request) begin
                hold_request = 1'b0;
                stall = LONG_HOLD;
            end else if (receiver_steady || $urandom_range(0, 3) != 0) begin
                stall = 0;
            end else begin
                stall = pick_gap() + 1;
            end
            if (stall == 0) begin
                tok_ready <= 1'b1;
                @(posedge clk);
            end else begin
                tok_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
        end
    end

    // Character side and verdict.
    initial begin
        int first;
        int words;
        int i;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Lookahead chains, high bytes, two tokens from one character, tab, CR and LF.
        send_text("===!=!");
        send_char(st_pkg::CH_NUL);
        send_text("return");
        send_char(st_pkg::CH_TAB);
        send_text("9");
        send_char(8'hFF);
        send_text("_");
        send_char(st_pkg::CH_NUL);
        send_char(8'h80);
        send_char(st_pkg::CH_CR);
        send_text("+");
        send_char(st_pkg::CH_LF);
        send_char(8'h7F);
        send_char(st_pkg::CH_NUL);
        drain_tokens();

        // A long identifier is never a keyword and runs straight into an integer.
        sender_steady = 1'b1;
        for (i = 0; i < LONG_WORD; i++) send_char(random_letter());
        send_text("1234567890==");
        send_char(st_pkg::CH_SPACE);
        send_text("!");
        send_char(st_pkg::CH_NUL);
        sender_steady = 1'b0;
        drain_tokens();

        // Random source text.
        first = chars_sent;
        words = 0;
        while (chars_sent - first < TEXT_CHARS) begin
            if (words == 100) begin
                // Fill the token queue while the output is held off.
                hold_request = 1'b1;
                for (i = 0; i < 12; i++) send_char(";");
            end
            if (words % 150 == 75) drain_tokens();
            sender_steady = (words >= 400 && words < 480);
            receiver_steady = sender_steady;
            send_word();
            words++;
        end
        sender_steady = 1'b0;
        receiver_steady = 1'b0;
        send_char(st_pkg::CH_NUL);
        drain_tokens();
        repeat (END_SLACK) @(posedge clk);

        $display("Covered %0d characters and %0d checked tokens, %0d of 27 token types.",
                 chars_sent, tokens_checked, $countones(types_seen));
        $display("Included long identifiers, keyword near misses and a long output hold.");
        if (fail_count == 0) begin
            $display("[source_tokenizer] OK");
        end else begin
            $display("[source_tokenizer] ERROR");
        end
        $finish;
    end

    // Watchdog.
    initial begin
        #(LIMIT_NS);
        $display("[source_tokenizer] ERROR");
        $finish;
    end

endmodule
